FILE: design/rmsn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmsn_pkg
// Types and fixed constants shared by the RMS normalizer modules.
// ----------------------------------------------------------------------------
package rmsn_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_LEN     = 4096;
    localparam int LEN_W       = 13;
    localparam int EPS_W       = 24;
    localparam int SUM_W       = 43;
    localparam int MEAN_W      = 44;
    localparam int ROOT_W      = 22;
    localparam int INV_W       = 29;
    localparam int PROD1_W     = 31;
    localparam int PROD2_W     = 60;
    localparam int FRAC_BITS   = 28;
    localparam int CFG_IDX_W   = 2;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(MAX_LEN);
    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(168);
    localparam logic [INV_W-1:0] UNIT_INV  = INV_W'(1) << FRAC_BITS;

    localparam logic signed [SAMPLE_BITS-1:0] SAT_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAT_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON       = 2'd1;

    // input actions
    localparam logic ACT_ACCUMULATE = 1'b0;
    localparam logic ACT_NORMALIZE  = 1'b1;

    typedef struct packed {
        logic                          action;
        logic signed [SAMPLE_BITS-1:0] x_value;
        logic signed [SAMPLE_BITS-1:0] weight_value;
    } rmsn_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_value;
        logic                          saturated;
        logic                          last;
    } rmsn_out_t;

    typedef struct packed {
        logic load_in;
        logic mul1;
        logic acc;
        logic div_sum;
        logic ld_mean;
        logic sqrt_start;
        logic inv_unit;
        logic div_inv;
        logic ld_inv;
        logic mul2;
        logic emit;
    } rmsn_cmd_t;

    typedef struct packed {
        logic action;
        logic close;
        logic div_done;
        logic sqrt_done;
        logic root_zero;
        logic out_free;
    } rmsn_status_t;

endpackage

FILE: design/rmsn_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmsn_div
// Restoring divider, one quotient bit per cycle, shared by the mean and the
// reciprocal of the root.
// ----------------------------------------------------------------------------
module rmsn_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rmsn_pkg::SUM_W-1:0]    dividend,
    input  logic [rmsn_pkg::ROOT_W-1:0]   divisor,
    output logic                          done,
    output logic [rmsn_pkg::SUM_W-1:0]    quotient
);
    import rmsn_pkg::*;

    localparam int CNT_W = $clog2(SUM_W);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [ROOT_W-1:0]   rem_reg;
    logic [ROOT_W-1:0]   rem_next;
    logic [ROOT_W-1:0]   den_reg;
    logic [SUM_W-1:0]    quo_reg;
    logic [ROOT_W:0]     rem_shift;
    logic [ROOT_W:0]     diff;
    logic                qbit;

    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign diff      = rem_shift - {1'b0, den_reg};
    assign qbit      = (rem_shift >= {1'b0, den_reg});
    assign rem_next  = qbit ? diff[ROOT_W-1:0] : rem_shift[ROOT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(SUM_W - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[SUM_W-2:0], qbit};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: design/rmsn_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmsn_sqrt
// Digit-by-digit integer square root, one root bit per cycle (floor).
// ----------------------------------------------------------------------------
module rmsn_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rmsn_pkg::MEAN_W-1:0]   radicand,
    output logic                          done,
    output logic [rmsn_pkg::ROOT_W-1:0]   root
);
    import rmsn_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W);
    localparam int REM_W = ROOT_W + 2;

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [MEAN_W-1:0]   val_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [REM_W+1:0]    rem_shift;
    logic [REM_W+1:0]    trial;
    logic [REM_W+1:0]    diff;
    logic                rbit;

    assign rem_shift = {rem_reg, val_reg[MEAN_W-1 -: 2]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign diff      = rem_shift - trial;
    assign rbit      = (rem_shift >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(ROOT_W - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            val_reg  <= {val_reg[MEAN_W-3:0], 2'b00};
            rem_reg  <= rbit ? diff[REM_W-1:0] : rem_shift[REM_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], rbit};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: design/rmsn_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmsn_dpath
// Datapath: configuration registers, square accumulation, mean / root /
// reciprocal units, two-stage multiply, saturation and the output register.
// ----------------------------------------------------------------------------
module rmsn_dpath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rmsn_pkg::rmsn_cmd_t                cmd,
    output rmsn_pkg::rmsn_status_t             status,
    input  rmsn_pkg::rmsn_in_t                 in_data,
    input  logic                               cfg_we,
    input  logic [rmsn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rmsn_pkg::EPS_W-1:0]         cfg_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output rmsn_pkg::rmsn_out_t                out_data
);
    import rmsn_pkg::*;

    logic [LEN_W-1:0]             vector_length_reg;
    logic [EPS_W-1:0]             epsilon_reg;
    logic [SUM_W-1:0]             sum_reg;
    logic [LEN_W-1:0]             acc_cnt_reg;
    logic [LEN_W-1:0]             out_cnt_reg;
    logic [INV_W-1:0]             inv_reg;
    logic [MEAN_W-1:0]            mean_reg;
    logic                         action_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] w_reg;
    logic [PROD1_W-1:0]           p1_reg;
    logic [PROD2_W-1:0]           p2_reg;
    logic                         out_valid_reg;
    rmsn_out_t                    out_reg;
    rmsn_out_t                    out_next;

    logic [LEN_W-1:0]             eff_len;
    logic [SAMPLE_BITS-1:0]       xmag;
    logic [SAMPLE_BITS-1:0]       wmag;
    logic [SAMPLE_BITS-1:0]       op_b;
    logic [SUM_W-1:0]             sum_add;
    logic                         acc_close;
    logic                         out_close;
    logic                         neg;
    logic [PROD2_W-FRAC_BITS-1:0] q_hi;
    logic                         frac_nz;
    logic [PROD2_W-FRAC_BITS:0]   q_neg;
    logic [SAMPLE_BITS-1:0]       q_neg_lo;

    logic                         div_start;
    logic [SUM_W-1:0]             div_dividend;
    logic [ROOT_W-1:0]            div_divisor;
    logic                         div_done;
    logic [SUM_W-1:0]             div_quotient;
    logic                         sqrt_done;
    logic [ROOT_W-1:0]            sqrt_root;

    assign eff_len   = (vector_length_reg == '0) ? LEN_W'(1) : vector_length_reg;
    assign xmag      = x_reg[SAMPLE_BITS-1] ? (~x_reg + 1'b1) : x_reg;
    assign wmag      = w_reg[SAMPLE_BITS-1] ? (~w_reg + 1'b1) : w_reg;
    assign op_b      = (action_reg == ACT_NORMALIZE) ? wmag : xmag;
    assign sum_add   = sum_reg + SUM_W'(p1_reg);
    assign acc_close = ({1'b0, acc_cnt_reg} + 1'b1) >= {1'b0, eff_len};
    assign out_close = ({1'b0, out_cnt_reg} + 1'b1) >= {1'b0, eff_len};

    // config writes must arrive only while idle; the block itself does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vector_length_reg <= LEN_RESET;
            epsilon_reg       <= EPS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_VECTOR_LENGTH: vector_length_reg <= cfg_data[LEN_W-1:0];
                CFG_EPSILON:       epsilon_reg       <= cfg_data;
                default:           ;
            endcase
        end
    end

    // ---------------- mean, root and reciprocal units ----------------
    assign div_start    = cmd.div_sum | cmd.div_inv;
    assign div_dividend = cmd.div_sum ? sum_add : SUM_W'(UNIT_INV);
    assign div_divisor  = cmd.div_sum ? ROOT_W'(eff_len) : sqrt_root;

    rmsn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    rmsn_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (mean_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // ---------------- state kept across items ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg     <= '0;
            acc_cnt_reg <= '0;
            out_cnt_reg <= '0;
            inv_reg     <= UNIT_INV;
        end
        else
        begin
            if (cmd.acc)
            begin
                if (acc_close)
                begin
                    sum_reg     <= '0;
                    acc_cnt_reg <= '0;
                end
                else
                begin
                    sum_reg     <= sum_add;
                    acc_cnt_reg <= acc_cnt_reg + 1'b1;
                end
            end
            if (cmd.emit)
            begin
                out_cnt_reg <= out_close ? '0 : out_cnt_reg + 1'b1;
            end
            if (cmd.inv_unit)
            begin
                inv_reg <= UNIT_INV;
            end
            else if (cmd.ld_inv)
            begin
                inv_reg <= div_quotient[INV_W-1:0];
            end
        end
    end

    // ---------------- item payload pipeline ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            action_reg <= in_data.action;
            x_reg      <= in_data.x_value;
            w_reg      <= in_data.weight_value;
        end
        if (cmd.mul1)
        begin
            p1_reg <= PROD1_W'(xmag) * PROD1_W'(op_b);
        end
        if (cmd.mul2)
        begin
            p2_reg <= PROD2_W'(p1_reg) * PROD2_W'(inv_reg);
        end
        if (cmd.ld_mean)
        begin
            mean_reg <= {1'b0, div_quotient} + MEAN_W'(epsilon_reg);
        end
    end

    // ---------------- rounding and saturation ----------------
    assign neg      = x_reg[SAMPLE_BITS-1] ^ w_reg[SAMPLE_BITS-1];
    assign q_hi     = p2_reg[PROD2_W-1:FRAC_BITS];
    assign frac_nz  = |p2_reg[FRAC_BITS-1:0];
    assign q_neg    = {1'b0, q_hi} + (PROD2_W-FRAC_BITS+1)'(frac_nz);
    assign q_neg_lo = q_neg[SAMPLE_BITS-1:0];

    always_comb
    begin
        out_next.last = out_close;
        if (neg)
        begin
            // floor of a negative quotient: round the magnitude up
            if (q_neg > (PROD2_W-FRAC_BITS+1)'($unsigned(SAT_NEG)))
            begin
                out_next.out_value = SAT_NEG;
                out_next.saturated = 1'b1;
            end
            else
            begin
                out_next.out_value = ~q_neg_lo + 1'b1;
                out_next.saturated = 1'b0;
            end
        end
        else
        begin
            if (q_hi > (PROD2_W-FRAC_BITS)'(SAT_POS))
            begin
                out_next.out_value = SAT_POS;
                out_next.saturated = 1'b1;
            end
            else
            begin
                out_next.out_value = q_hi[SAMPLE_BITS-1:0];
                out_next.saturated = 1'b0;
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign status.action    = action_reg;
    assign status.close     = acc_close;
    assign status.div_done  = div_done;
    assign status.sqrt_done = sqrt_done;
    assign status.root_zero = (sqrt_root == '0);
    assign status.out_free  = !out_valid_reg || !out_stall;

endmodule

FILE: design/rmsn_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmsn_ctrl
// Sequencer: steps each request through multiply, accumulate or emit, and
// runs the mean / root / reciprocal sequence at the end of a vector.
// ----------------------------------------------------------------------------
module rmsn_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  rmsn_pkg::rmsn_status_t  status,
    output rmsn_pkg::rmsn_cmd_t     cmd
);
    import rmsn_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MUL1 = 4'd1;
    localparam logic [3:0] ST_ACC  = 4'd2;
    localparam logic [3:0] ST_MUL2 = 4'd3;
    localparam logic [3:0] ST_EMIT = 4'd4;
    localparam logic [3:0] ST_DIVW = 4'd5;
    localparam logic [3:0] ST_SQS  = 4'd6;
    localparam logic [3:0] ST_SQW  = 4'd7;
    localparam logic [3:0] ST_INVW = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = (status.action == ACT_NORMALIZE) ? ST_MUL2 : ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (status.close)
                begin
                    cmd.div_sum = 1'b1;
                    state_next  = ST_DIVW;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIVW:
            begin
                if (status.div_done)
                begin
                    cmd.ld_mean = 1'b1;
                    state_next  = ST_SQS;
                end
            end
            ST_SQS:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = ST_SQW;
            end
            ST_SQW:
            begin
                if (status.sqrt_done)
                begin
                    if (status.root_zero)
                    begin
                        cmd.inv_unit = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        cmd.div_inv = 1'b1;
                        state_next  = ST_INVW;
                    end
                end
            end
            ST_INVW:
            begin
                if (status.div_done)
                begin
                    cmd.ld_inv = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

FILE: design/rms_normalizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_normalizer_top
// Two-pass RMS normalizer for signed Q4.12 vectors.
// ----------------------------------------------------------------------------
// One request is in flight at a time. An accumulate request is loaded,
// multiplied and accumulated; a normalize request is loaded, multiplied
// twice and emitted, and waits to emit while the output register stays
// stalled. The request that closes a vector goes on: a bit-serial divider
// forms the mean, a bit-serial square root follows and the same divider
// forms 2^28 / root, a step skipped for unit gain when the root is zero.
// The result register sits between the core and the output, so a finished
// result waiting downstream does not stop the next request from being
// accepted. Configuration writes are always ready and must be issued only
// while no request is in flight.
// ----------------------------------------------------------------------------
module rms_normalizer_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  rmsn_pkg::rmsn_in_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output rmsn_pkg::rmsn_out_t                out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rmsn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rmsn_pkg::EPS_W-1:0]         cfg_data
);
    import rmsn_pkg::*;

    rmsn_cmd_t    cmd;
    rmsn_status_t status;

    assign cfg_ready = 1'b1;

    rmsn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    rmsn_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

FILE: design/rmsn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmsn_checker
// Port-level checks for the RMS normalizer, bound to the top level.
// ----------------------------------------------------------------------------
module rmsn_port_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  rmsn_pkg::rmsn_out_t                out_data
);
    import rmsn_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

    // one request at a time: busy right after acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("request accepted while another is in flight");

    // a new result appears only while a request is being processed
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
    else $error("result without a request in flight");

    // a clipped result sits at one of the rails
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.saturated |->
            (out_data.out_value == SAT_POS) || (out_data.out_value == SAT_NEG))
    else $error("saturated result off the rails");

endmodule

bind rms_normalizer_top rmsn_port_checker u_rmsn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

FILE: tb/rmsn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmsn_checker
// Watches the request, result and register channels of the RMS normalizer,
// keeps its own copy of the accumulator, counters and inverse root, and
// compares every accepted result against the oldest predicted one.
// ----------------------------------------------------------------------------
module rmsn_checker
    import rmsn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  rmsn_in_t   in_data,
    input  logic       out_valid,
    input  logic       out_stall,
    input  rmsn_out_t  out_data,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [EPS_W-1:0]     cfg_data,
    input  logic       end_of_test,
    output int         fail_count,
    output int         pending,
    output int         results_checked,
    output int         vectors_closed,
    output int         saturated_seen
);

    localparam int PRINT_CAP = 40;

    logic [LEN_W-1:0] length_reg;
    logic [EPS_W-1:0] eps_reg;
    logic [SUM_W-1:0] square_sum;
    logic [LEN_W-1:0] acc_count;
    logic [LEN_W-1:0] out_count;
    logic [INV_W-1:0] inv_root;
    rmsn_out_t        norm_queue[$];
    bit               leftovers_reported;

    initial begin
        fail_count      = 0;
        pending         = 0;
        results_checked = 0;
        vectors_closed  = 0;
        saturated_seen  = 0;
        leftovers_reported = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (fail_count < PRINT_CAP)
            $display("ERROR @%0t: %s", $time, msg);
        fail_count++;
    endtask

    function automatic logic [63:0] magnitude(input logic signed [SAMPLE_BITS-1:0] v);
        longint s;
        s = v;
        return (s < 0) ? 64'(-s) : 64'(s);
    endfunction

    // floor(2^28 / floor(sqrt(sum / len + eps))), unit gain for a zero root
    function automatic logic [INV_W-1:0] inverse_of_rms(input logic [SUM_W-1:0] sum,
                                                         input int unsigned len,
                                                         input logic [EPS_W-1:0] eps);
        logic [63:0] mean_sq;
        logic [63:0] root;
        logic [63:0] trial;
        int          b;
        mean_sq = 64'(sum) / 64'(len) + 64'(eps);
        root = '0;
        for (b = ROOT_W; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= mean_sq)
                root = trial;
        end
        if (root == 0)
            return UNIT_INV;
        return INV_W'(64'(UNIT_INV) / root);
    endfunction

    function automatic rmsn_out_t normalized(input rmsn_in_t req,
                                             input logic [INV_W-1:0] inv,
                                             input logic is_last);
        logic [63:0] prod;
        logic [63:0] q;
        logic        neg;
        rmsn_out_t   r;
        neg  = req.x_value[SAMPLE_BITS-1] ^ req.weight_value[SAMPLE_BITS-1];
        prod = magnitude(req.x_value) * 64'(inv) * magnitude(req.weight_value);
        r.saturated = 1'b0;
        r.last      = is_last;
        if (neg) begin
            // round the magnitude up so the signed result floors
            q = (prod >> FRAC_BITS) + 64'(|prod[FRAC_BITS-1:0]);
            if (q > (64'd1 << (SAMPLE_BITS-1))) begin
                q = 64'd1 << (SAMPLE_BITS-1);
                r.saturated = 1'b1;
            end
            r.out_value = SAMPLE_BITS'(64'd0 - q);
        end else begin
            q = prod >> FRAC_BITS;
            if (q > ((64'd1 << (SAMPLE_BITS-1)) - 1)) begin
                q = (64'd1 << (SAMPLE_BITS-1)) - 1;
                r.saturated = 1'b1;
            end
            r.out_value = SAMPLE_BITS'(q);
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        int unsigned len_eff;
        logic        is_last;
        rmsn_out_t   want;
        rmsn_out_t   got;
        if (!rst_n) begin
            length_reg = LEN_RESET;
            eps_reg    = EPS_RESET;
            square_sum = '0;
            acc_count  = '0;
            out_count  = '0;
            inv_root   = UNIT_INV;
            norm_queue.delete();
            pending    = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_VECTOR_LENGTH: length_reg = cfg_data[LEN_W-1:0];
                    CFG_EPSILON:       eps_reg    = cfg_data;
                    default: ;
                endcase
            end

            if (in_valid && !in_stall) begin
                len_eff = (length_reg == 0) ? 1 : length_reg;
                if (in_data.action == ACT_ACCUMULATE) begin
                    square_sum = square_sum + SUM_W'(magnitude(in_data.x_value)
                                                     * magnitude(in_data.x_value));
                    if (32'(acc_count) + 1 >= len_eff) begin
                        inv_root   = inverse_of_rms(square_sum, len_eff, eps_reg);
                        square_sum = '0;
                        acc_count  = '0;
                        vectors_closed++;
                    end else begin
                        acc_count = acc_count + 1'b1;
                    end
                end else begin
                    is_last = (32'(out_count) + 1 >= len_eff);
                    norm_queue.push_back(normalized(in_data, inv_root, is_last));
                    out_count = is_last ? '0 : out_count + 1'b1;
                end
            end

            if (out_valid && !out_stall) begin
                got = out_data;
                if (norm_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected result out_value=%0d sat=%0b last=%0b",
                                              got.out_value, got.saturated, got.last));
                end else begin
                    want = norm_queue.pop_front();
                    results_checked++;
                    if (got.saturated)
                        saturated_seen++;
                    if (got.out_value !== want.out_value)
                        report_mismatch($sformatf("out_value got %0d want %0d",
                                                  got.out_value, want.out_value));
                    if (got.saturated !== want.saturated)
                        report_mismatch($sformatf("saturated got %0b want %0b",
                                                  got.saturated, want.saturated));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last got %0b want %0b",
                                                  got.last, want.last));
                end
            end

            if (end_of_test && !leftovers_reported) begin
                leftovers_reported = 1'b1;
                while (norm_queue.size() != 0) begin
                    want = norm_queue.pop_front();
                    report_mismatch($sformatf("missing result out_value=%0d", want.out_value));
                end
            end

            pending = norm_queue.size();
        end
    end

endmodule

FILE: tb/tb_rms_normalizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rms_normalizer_top
// Drives normalize and accumulate requests and register writes into the
// RMS normalizer with random idle and stall cycles; the checker beside the
// block predicts and compares each result.
// ----------------------------------------------------------------------------
module tb_rms_normalizer_top;
    import rmsn_pkg::*;

    localparam int RANDOM_ITEMS   = 700;
    localparam int IDLE_PCT       = 15;
    localparam int SETTLE_CYCLES  = 200;
    localparam int TIMEOUT_CYCLES = 1500000;
    localparam logic [EPS_W-1:0] EPS_MAX = {EPS_W{1'b1}};

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    rmsn_in_t  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    rmsn_out_t out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [EPS_W-1:0]     cfg_data  = '0;
    logic      end_of_test = 1'b0;

    int fail_count;
    int pending;
    int results_checked;
    int vectors_closed;
    int saturated_seen;

    bit quiet = 1'b0;
    int requests_sent = 0;
    int cfg_writes = 0;
    int cur_len = MAX_LEN;

    always #2 clk = ~clk;

    rms_normalizer_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rmsn_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_data        (out_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .end_of_test     (end_of_test),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .vectors_closed  (vectors_closed),
        .saturated_seen  (saturated_seen)
    );

    always @(negedge clk)
        out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic drive_request(input logic act,
                                 input logic signed [SAMPLE_BITS-1:0] x,
                                 input logic signed [SAMPLE_BITS-1:0] w);
        rmsn_in_t req;
        req.action       = act;
        req.x_value      = x;
        req.weight_value = w;
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        requests_sent++;
    endtask

    // hold off until every result is back and a closing request has finished
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [EPS_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
        cfg_writes++;
        if (idx == CFG_VECTOR_LENGTH)
            cur_len = data[LEN_W-1:0];
    endtask

    task automatic configure(input int len, input logic [EPS_W-1:0] eps);
        wait_drained();
        write_register(CFG_VECTOR_LENGTH, EPS_W'(len));
        write_register(CFG_EPSILON, eps);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] rand_element();
        case ($urandom_range(0, 9))
            0, 1:    return SAMPLE_BITS'($urandom);
            2:       return $urandom_range(0, 1) ? SAT_POS : SAT_NEG;
            default: return SAMPLE_BITS'($urandom_range(0, 16383)) - SAMPLE_BITS'(8192);
        endcase
    endfunction

    // gains mostly near one in Q4.12
    function automatic logic signed [SAMPLE_BITS-1:0] rand_gain();
        logic signed [SAMPLE_BITS-1:0] g;
        if ($urandom_range(0, 4) == 0)
            return SAMPLE_BITS'($urandom);
        g = SAMPLE_BITS'($urandom_range(2048, 6143));
        return $urandom_range(0, 5) == 0 ? -g : g;
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)  return 0;
        if (r < 13) return 1;
        if (r < 85) return $urandom_range(2, 16);
        return $urandom_range(17, 64);
    endfunction

    function automatic logic [EPS_W-1:0] pick_epsilon();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return EPS_MAX;
        if (r < 8)  return EPS_W'($urandom_range(1, 4095));
        return EPS_W'($urandom);
    endfunction

    function automatic int effective_len();
        return (cur_len == 0) ? 1 : cur_len;
    endfunction

    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge clk);
        $display("TIMEOUT: results still outstanding: %0d", pending);
        $display("rms_normalizer_top: mismatch");
        $finish;
    end

    initial begin
        int random_start;
        int phase;
        int kind;
        int n;
        int i;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // unit gain straight out of reset, field extremes
        drive_request(ACT_NORMALIZE, 1, 1);
        drive_request(ACT_NORMALIZE, -1, 1);
        drive_request(ACT_NORMALIZE, SAT_POS, SAT_POS);
        drive_request(ACT_NORMALIZE, SAT_NEG, SAT_POS);
        drive_request(ACT_NORMALIZE, SAT_NEG, SAT_NEG);
        drive_request(ACT_NORMALIZE, 0, SAT_NEG);
        drive_request(ACT_NORMALIZE, 3, -5);
        drive_request(ACT_NORMALIZE, SAT_NEG, 1);
        drive_request(ACT_NORMALIZE, SAT_POS, -1);

        // zero sum with zero epsilon keeps unit gain; output count already past length
        configure(4, '0);
        repeat (4) drive_request(ACT_ACCUMULATE, 0, rand_gain());
        drive_request(ACT_NORMALIZE, 2, -3);
        drive_request(ACT_NORMALIZE, rand_element(), rand_gain());
        drive_request(ACT_NORMALIZE, -7, 9);

        // zero length acts as one, largest epsilon
        configure(0, EPS_MAX);
        drive_request(ACT_ACCUMULATE, SAT_NEG, SAT_POS);
        drive_request(ACT_NORMALIZE, SAT_POS, SAT_NEG);
        drive_request(ACT_ACCUMULATE, SAT_POS, SAT_NEG);
        drive_request(ACT_NORMALIZE, SAT_NEG, SAT_NEG);

        // shorten the length while a vector is half accumulated
        configure(6, EPS_RESET);
        repeat (3) drive_request(ACT_ACCUMULATE, rand_element(), rand_gain());
        wait_drained();
        write_register(CFG_VECTOR_LENGTH, EPS_W'(2));
        drive_request(ACT_ACCUMULATE, rand_element(), rand_gain());
        drive_request(ACT_NORMALIZE, rand_element(), rand_gain());
        drive_request(ACT_NORMALIZE, rand_element(), rand_gain());

        random_start = requests_sent;
        phase = 0;
        while (requests_sent - random_start < RANDOM_ITEMS) begin
            quiet = (phase >= 12 && phase < 22);
            if (phase == 6)
                wait_drained();
            if ($urandom_range(0, 99) < 30)
                configure(pick_length(), pick_epsilon());
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                // well-formed vector: full accumulate pass, then full output pass
                n = effective_len();
                for (i = 0; i < n; i++)
                    drive_request(ACT_ACCUMULATE, rand_element(), SAMPLE_BITS'($urandom));
                for (i = 0; i < n; i++)
                    drive_request(ACT_NORMALIZE, rand_element(), rand_gain());
            end else if (kind < 85) begin
                // broken vector: partial or overlong passes
                n = $urandom_range(0, 2 * effective_len());
                for (i = 0; i < n; i++)
                    drive_request(ACT_ACCUMULATE, rand_element(), rand_gain());
                n = $urandom_range(0, effective_len() + 3);
                for (i = 0; i < n; i++)
                    drive_request(ACT_NORMALIZE, rand_element(), rand_gain());
            end else begin
                n = $urandom_range(1, 10);
                for (i = 0; i < n; i++)
                    drive_request($urandom_range(0, 1) ? ACT_NORMALIZE : ACT_ACCUMULATE,
                                  SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
            end
            phase++;
        end
        quiet = 1'b0;

        // longest length: outputs stay well short of the end of a vector
        configure(MAX_LEN, pick_epsilon());
        repeat (12) drive_request(ACT_NORMALIZE, rand_element(), rand_gain());

        wait_drained();
        end_of_test <= 1'b1;
        repeat (2) @(negedge clk);

        $display("Summary: %0d requests, %0d register writes, %0d vectors closed",
                 requests_sent, cfg_writes, vectors_closed);
        $display("Summary: %0d normalized results checked, %0d of them saturated",
                 results_checked, saturated_seen);
        if (fail_count == 0)
            $display("rms_normalizer_top: match");
        else
            $display("rms_normalizer_top: mismatch");
        $finish;
    end

endmodule
